// ===== src/dpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpwm_pkg
// constants, codes and the quarter-wave sine rom for the dpwm duty generator
// ----------------------------------------------------------------------------
package dpwm_pkg;

    // cosine rom resolution: phase truncated to this many top bits
    localparam int COS_TABLE_BITS = 10;
    localparam int QTR_BITS       = COS_TABLE_BITS - 2;
    localparam int QTR_ENTRIES    = 1 << QTR_BITS;
    localparam int ROM_IDX_W      = QTR_BITS + 1;

    localparam int ANGLE_W = 16;
    localparam int MOD_W   = 16;
    localparam int DUTY_W  = 16;
    localparam int MODE_W  = 3;
    localparam int COS_W   = 17;                 // signed q1.15, -1.0 .. +1.0
    localparam int PROD_W  = COS_W + MOD_W + 1;  // signed q30 product
    localparam int LEVEL_W = 35;                 // signed q31 duty before clamp

    // pattern codes
    localparam logic [MODE_W-1:0] MODE_SINE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DPWM1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DPWM2 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DPWM3 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DPWM4 = 3'd4;

    // sector edges, k * 65536 / 12 rounded
    localparam logic [ANGLE_W-1:0] DEG30  = 16'd5461;
    localparam logic [ANGLE_W-1:0] DEG60  = 16'd10923;
    localparam logic [ANGLE_W-1:0] DEG90  = 16'd16384;
    localparam logic [ANGLE_W-1:0] DEG120 = 16'd21845;
    localparam logic [ANGLE_W-1:0] DEG150 = 16'd27307;
    localparam logic [ANGLE_W-1:0] DEG180 = 16'd32768;
    localparam logic [ANGLE_W-1:0] DEG210 = 16'd38229;
    localparam logic [ANGLE_W-1:0] DEG240 = 16'd43691;
    localparam logic [ANGLE_W-1:0] DEG270 = 16'd49152;
    localparam logic [ANGLE_W-1:0] DEG300 = 16'd54613;
    localparam logic [ANGLE_W-1:0] DEG330 = 16'd60075;

    localparam logic [ANGLE_W-1:0] SHIFT30 = DEG30;
    localparam logic [15:0] SQRT3_Q15 = 16'd56756;

    localparam logic signed [LEVEL_W-1:0] LEVEL_HALF = 35'sd1073741824;
    localparam logic signed [LEVEL_W-1:0] LEVEL_ONE  = 35'sd2147483648;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 16'd32768;

    // which rotated angle feeds the cosine lookup
    typedef enum logic [1:0] {
        SEL_BASE,
        SEL_LAG,
        SEL_LEAD
    } phase_sel_t;

    // how the m*cos product becomes the q31 level
    typedef enum logic [2:0] {
        OP_HALF_COS,
        OP_SQRT3,
        OP_TWO,
        OP_TWO_ONE,
        OP_ZERO,
        OP_ONE
    } level_op_t;

    typedef logic [15:0] sin_rom_t [0:QTR_ENTRIES];

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    // sin(pi/2 * j / QTR_ENTRIES) in q15, taylor series in q30, evaluated at elaboration
    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        longint unsigned t;
        longint unsigned r;
        longint unsigned r2;
        longint unsigned h;
        longint unsigned s;
        longint unsigned q;
        for (int j = 0; j <= QTR_ENTRIES; j++)
        begin
            t  = longint'(j) << (18 - COS_TABLE_BITS);
            r  = (t * PIH_Q30) >> 16;
            r2 = (r * r) >> 30;
            h  = Q30_ONE - r2 / 72;
            h  = Q30_ONE - ((r2 * h) >> 30) / 42;
            h  = Q30_ONE - ((r2 * h) >> 30) / 20;
            h  = Q30_ONE - ((r2 * h) >> 30) / 6;
            s  = (r * h) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32768)
            begin
                q = 64'd32768;
            end
            rom[j] = q[15:0];
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// ===== src/discontinuous_pwm_duty.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discontinuous_pwm_duty
// one-phase pwm duty from electrical angle and modulation index, five patterns
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid / in_stall    | phase_angle, mod_index
//  out     | source    | out_valid / out_stall  | duty
//  cfg     | sink      | cfg_wr_en              | cfg_wr_data (pattern mode)
//
//  one request per clock sustained while the output is not stalled
//  five register stages: input, cosine rom, multiplier, level, clamped output
//  each stage fills its bubble independently, so a stalled result still lets
//  earlier stages take requests until the pipe is full
//  async active-low reset clears valids and sets the pattern to sinusoidal
// ----------------------------------------------------------------------------
module discontinuous_pwm_duty (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dpwm_pkg::MODE_W-1:0]         cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dpwm_pkg::ANGLE_W-1:0]        phase_angle,
    input  logic [dpwm_pkg::MOD_W-1:0]          mod_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dpwm_pkg::DUTY_W-1:0]         duty
);
    import dpwm_pkg::*;

    // pattern register
    logic [MODE_W-1:0] mode_reg;

    // stage valids
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    // per-stage readiness, each stage moves if empty or its successor moves
    logic ready0;
    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;

    // stage 0: captured request
    logic [ANGLE_W-1:0] angle_reg;
    logic [MOD_W-1:0]   mod0_reg;

    // stage 0 logic: sector decode and cosine lookup
    phase_sel_t             sel_next;
    level_op_t              op_next;
    logic [ANGLE_W-1:0]     look_angle;
    logic [1:0]             quad;
    logic [QTR_BITS-1:0]    qtr_pos;
    logic [ROM_IDX_W-1:0]   rom_idx;
    logic [15:0]            sin_mag;
    logic                   cos_neg;
    logic signed [COS_W-1:0] cos_next;

    // stage 1: cosine and index
    logic signed [COS_W-1:0] cos_reg;
    logic [MOD_W-1:0]        mod1_reg;
    level_op_t               op1_reg;

    // stage 2: m * cos in q30
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    level_op_t                op2_reg;

    // stage 2 logic: level in q31
    logic [30:0]               prod_mag;
    logic [46:0]               sq_prod;
    logic [46:0]               sq_round;
    logic [31:0]               sq_term;
    logic signed [LEVEL_W-1:0] prod_ext;
    logic signed [LEVEL_W-1:0] level_next;
    logic signed [LEVEL_W-1:0] level_reg;

    // stage 3 logic: clamp and round to q15
    logic [32:0]        round_sum;
    logic [DUTY_W-1:0]  duty_next;
    logic [DUTY_W-1:0]  duty_reg;

    // ---------------------------------------------------------------- control
    assign ready4 = !out_valid_reg || !out_stall;
    assign ready3 = !s3_valid_reg || ready4;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign ready0 = !s0_valid_reg || ready1;

    assign in_stall  = !ready0;
    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SINE;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (ready0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (ready1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------- stage 0
    always_ff @(posedge clk)
    begin
        if (ready0 && in_valid)
        begin
            angle_reg <= phase_angle;
            mod0_reg  <= mod_index;
        end
    end

    // sector decode: picks the rotated cosine and how it turns into a level
    always_comb
    begin
        sel_next = SEL_BASE;
        op_next  = OP_HALF_COS;
        unique case (mode_reg)
            MODE_DPWM1:
            begin
                if (angle_reg >= DEG300)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_HALF_COS;
                end
                else if (angle_reg >= DEG240)
                begin
                    sel_next = SEL_BASE;
                    op_next  = OP_SQRT3;
                end
                else if (angle_reg >= DEG180)
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_HALF_COS;
                end
                else if (angle_reg >= DEG120)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_HALF_COS;
                end
                else if (angle_reg >= DEG60)
                begin
                    sel_next = SEL_BASE;
                    op_next  = OP_SQRT3;
                end
                else
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_HALF_COS;
                end
            end
            MODE_DPWM2:
            begin
                if (angle_reg >= DEG330)
                begin
                    op_next = OP_ONE;
                end
                else if (angle_reg >= DEG270)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_TWO;
                end
                else if (angle_reg >= DEG210)
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_TWO_ONE;
                end
                else if (angle_reg >= DEG150)
                begin
                    op_next = OP_ZERO;
                end
                else if (angle_reg >= DEG90)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_TWO_ONE;
                end
                else if (angle_reg >= DEG30)
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_TWO;
                end
                else
                begin
                    op_next = OP_ONE;
                end
            end
            MODE_DPWM3:
            begin
                if (angle_reg >= DEG300)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_TWO;
                end
                else if (angle_reg >= DEG240)
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_TWO_ONE;
                end
                else if (angle_reg >= DEG180)
                begin
                    op_next = OP_ZERO;
                end
                else if (angle_reg >= DEG120)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_TWO_ONE;
                end
                else if (angle_reg >= DEG60)
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_TWO;
                end
                else
                begin
                    op_next = OP_ONE;
                end
            end
            MODE_DPWM4:
            begin
                if (angle_reg >= DEG240)
                begin
                    sel_next = SEL_LEAD;
                    op_next  = OP_TWO;
                end
                else if (angle_reg >= DEG120)
                begin
                    op_next = OP_ZERO;
                end
                else
                begin
                    sel_next = SEL_LAG;
                    op_next  = OP_TWO;
                end
            end
            default:
            begin
                // sinusoidal, also taken by the unused codes
                sel_next = SEL_BASE;
                op_next  = OP_HALF_COS;
            end
        endcase
    end

    // rotated angle, wraps modulo one turn
    always_comb
    begin
        case (sel_next)
            SEL_LAG:  look_angle = angle_reg - SHIFT30;
            SEL_LEAD: look_angle = angle_reg + SHIFT30;
            default:  look_angle = angle_reg;
        endcase
    end

    // quarter-wave cosine: quadrants 0 and 2 read the mirrored position,
    // quadrants 1 and 2 negate
    assign quad     = look_angle[ANGLE_W-1 -: 2];
    assign qtr_pos  = look_angle[ANGLE_W-3 -: QTR_BITS];
    assign rom_idx  = quad[0] ? {1'b0, qtr_pos}
                              : ROM_IDX_W'(QTR_ENTRIES) - {1'b0, qtr_pos};
    assign sin_mag  = SIN_ROM[rom_idx];
    assign cos_neg  = quad[1] ^ quad[0];
    assign cos_next = cos_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (ready1 && s0_valid_reg)
        begin
            cos_reg  <= cos_next;
            mod1_reg <= mod0_reg;
            op1_reg  <= op_next;
        end
    end

    assign prod_next = $signed({1'b0, mod1_reg}) * cos_reg;

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            prod_reg <= prod_next;
            op2_reg  <= op1_reg;
        end
    end

    // |m*cos| stays below 2^31
    assign prod_mag = prod_reg[PROD_W-1] ? 31'(-prod_reg) : prod_reg[30:0];
    assign sq_prod  = prod_mag * SQRT3_Q15;
    assign sq_round = sq_prod + 47'd16384;
    assign sq_term  = sq_round[46:15];
    assign prod_ext = LEVEL_W'(prod_reg);

    always_comb
    begin
        case (op2_reg)
            OP_SQRT3:
            begin
                // rounded half away from zero, then offset by one half
                if (prod_reg[PROD_W-1])
                begin
                    level_next = LEVEL_HALF - $signed({3'b000, sq_term});
                end
                else
                begin
                    level_next = LEVEL_HALF + $signed({3'b000, sq_term});
                end
            end
            OP_TWO:     level_next = prod_ext <<< 1;
            OP_TWO_ONE: level_next = (prod_ext <<< 1) + LEVEL_ONE;
            OP_ZERO:    level_next = '0;
            OP_ONE:     level_next = LEVEL_ONE;
            default:    level_next = prod_ext + LEVEL_HALF;
        endcase
    end

    // ---------------------------------------------------------------- stage 3
    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            level_reg <= level_next;
        end
    end

    // clamp to [0, 1] and round q31 to q15
    assign round_sum = {1'b0, level_reg[31:0]} + 33'd32768;

    always_comb
    begin
        if (level_reg[LEVEL_W-1] || (level_reg == '0))
        begin
            duty_next = '0;
        end
        else if (level_reg >= LEVEL_ONE)
        begin
            duty_next = DUTY_FULL;
        end
        else
        begin
            duty_next = round_sum[31:16];
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk)
    begin
        if (ready4 && s3_valid_reg)
        begin
            duty_reg <= duty_next;
        end
    end

    // ---------------------------------------------------------------- checks
    // clamp keeps every delivered duty within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_reg <= DUTY_FULL))
        else $error("duty above full scale");

    // an empty output stage means no backpressure reaches the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty output");

    // a request in stage 0 moves on whenever stage 1 can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && ready1) |=> s1_valid_reg)
        else $error("request lost between stage 0 and stage 1");

    // forced-low sectors give a zero level
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && ready3 && (op2_reg == OP_ZERO)) |=> (level_reg == '0))
        else $error("zero sector gave non-zero level");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the one-phase dpwm duty generator
//
// a short directed set walks the sector edges, the field extremes and every
// pattern and spare code 7. A long random run follows, split into phases
// with one pattern setting each. Every accepted request is predicted in the
// scoreboard from its own fixed-point cosine and sector logic. Every accepted
// duty is checked in order. Both channels see random gaps and stalls, and the
// output side holds off for a long stretch now and then so the pipe backs up.
// ----------------------------------------------------------------------------
module testbench;

    import dpwm_pkg::*;

    // ------------------------------------------------------------------------
    // bench timing and run shape
    // ------------------------------------------------------------------------
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;       // idle margin after the pipe drains
    localparam int LONG_HOLD      = 64;      // output hold-off, well past pipe depth
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int PHASE_ITEMS    = 112;
    localparam int NUM_PHASES     = 12;
    localparam int NUM_PROBES     = 21;
    localparam int MAX_REPORTS    = 40;

    // unused pattern codes, decoded as sinusoidal
    localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    // ------------------------------------------------------------------------
    // fixed-point constants of the duty arithmetic
    // ------------------------------------------------------------------------
    localparam int ROM_DROP = 16 - COS_TABLE_BITS;   // phase bits below the rom address
    localparam logic [15:0] ROM_LOW_MASK = 16'((1 << ROM_DROP) - 1);

    localparam longint unsigned UNIT_Q30      = 64'd1073741824;
    localparam longint unsigned QTR_PI_SCALE  = 64'd1686629713;  // pi/2 in q30
    localparam longint unsigned ROOT3_Q15     = 64'd56756;
    localparam longint          LVL_HALF      = 64'sd1073741824;  // 0.5 in q31
    localparam longint          LVL_ONE       = 64'sd2147483648;  // 1.0 in q31
    localparam logic [15:0]     LAG_STEP      = 16'd5461;         // 30 degrees
    localparam logic [15:0]     FULL_ON       = 16'd32768;

    // sector edges, k * 65536 / 12 rounded
    localparam logic [15:0] ANG_30  = 16'd5461;
    localparam logic [15:0] ANG_60  = 16'd10923;
    localparam logic [15:0] ANG_90  = 16'd16384;
    localparam logic [15:0] ANG_120 = 16'd21845;
    localparam logic [15:0] ANG_150 = 16'd27307;
    localparam logic [15:0] ANG_180 = 16'd32768;
    localparam logic [15:0] ANG_210 = 16'd38229;
    localparam logic [15:0] ANG_240 = 16'd43691;
    localparam logic [15:0] ANG_270 = 16'd49152;
    localparam logic [15:0] ANG_300 = 16'd54613;
    localparam logic [15:0] ANG_330 = 16'd60075;

    localparam logic [15:0] SECTOR_EDGES [12] = '{
        16'd0, ANG_30, ANG_60, ANG_90, ANG_120, ANG_150,
        ANG_180, ANG_210, ANG_240, ANG_270, ANG_300, ANG_330
    };

    localparam logic [15:0] MOD_EXTREMES [6] = '{
        16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'd65535
    };

    // pattern used by each random phase: both extremes of the code range,
    // every discontinuous variant twice and all spare codes
    localparam logic [MODE_W-1:0] PHASE_MODES [NUM_PHASES] = '{
        MODE_DPWM1, MODE_DPWM2, MODE_DPWM3, MODE_DPWM4, MODE_SINE, MODE_SPARE6,
        MODE_DPWM2, MODE_DPWM4, MODE_DPWM1, MODE_DPWM3, MODE_SPARE5, MODE_SPARE7
    };

    // ------------------------------------------------------------------------
    // directed requests: saturation, zero index, sector edges either side,
    // table wrap at the top of the angle range and a spare pattern code
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [15:0]       angle;
        logic [15:0]       mi;
    } probe_t;

    localparam probe_t PROBES [NUM_PROBES] = '{
        '{MODE_SINE,   16'd0,     16'd32768},
        '{MODE_SINE,   16'd32768, 16'd32768},
        '{MODE_SINE,   16'd16384, 16'd65535},
        '{MODE_SINE,   16'd65535, 16'd0},
        '{MODE_SINE,   16'd0,     16'd65535},
        '{MODE_SPARE7, 16'd0,     16'd65535},
        '{MODE_SPARE7, 16'd32768, 16'd65535},
        '{MODE_DPWM1,  16'd10922, 16'd32768},
        '{MODE_DPWM1,  16'd10923, 16'd32768},
        '{MODE_DPWM1,  16'd43691, 16'd65535},
        '{MODE_DPWM2,  16'd5460,  16'd32768},
        '{MODE_DPWM2,  16'd5461,  16'd32768},
        '{MODE_DPWM2,  16'd27307, 16'd40000},
        '{MODE_DPWM2,  16'd60075, 16'd32768},
        '{MODE_DPWM3,  16'd54613, 16'd65535},
        '{MODE_DPWM3,  16'd32767, 16'd32768},
        '{MODE_DPWM3,  16'd0,     16'd0},
        '{MODE_DPWM4,  16'd21844, 16'd32768},
        '{MODE_DPWM4,  16'd21845, 16'd32768},
        '{MODE_DPWM4,  16'd43691, 16'd65535},
        '{MODE_DPWM4,  16'd65535, 16'd65535}
    };

    // one request in flight with the duty it should produce
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [15:0]       angle;
        logic [15:0]       mi;
        logic [15:0]       duty;
    } duty_expect_t;

    // ------------------------------------------------------------------------
    // scoreboard: duty predictor plus the in-order store of pending duties
    // ------------------------------------------------------------------------
    class duty_scoreboard;
        logic [MODE_W-1:0] mode;
        duty_expect_t      pending_duty [$];
        int                errors;
        int                n_requests;
        int                n_results;
        int                n_floor;
        int                n_full;

        function new();
            mode       = MODE_SINE;
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            n_floor    = 0;
            n_full     = 0;
        endfunction

        function int pending();
            return pending_duty.size();
        endfunction

        // sin(pi/2 * t / 65536) in q15, horner form in q30 with truncated products
        function longint unsigned quarter_sine(longint unsigned t);
            longint unsigned r;
            longint unsigned r2;
            longint unsigned h;
            longint unsigned s;
            longint unsigned q;
            r  = (t * QTR_PI_SCALE) >> 16;
            r2 = (r * r) >> 30;
            h  = UNIT_Q30 - r2 / 72;
            h  = UNIT_Q30 - ((r2 * h) >> 30) / 42;
            h  = UNIT_Q30 - ((r2 * h) >> 30) / 20;
            h  = UNIT_Q30 - ((r2 * h) >> 30) / 6;
            s  = (r * h) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32768)
            begin
                q = 64'd32768;
            end
            return q;
        endfunction

        // cosine of a truncated phase by quarter-wave symmetry
        function longint cos_lookup(logic [15:0] p);
            logic [15:0]     pt;
            longint unsigned t;
            pt = (p >> ROM_DROP) << ROM_DROP;
            t  = longint'(pt[13:0]) << 2;
            case (pt[15:14])
                2'd0:    return longint'(quarter_sine(64'd65536 - t));
                2'd1:    return -longint'(quarter_sine(t));
                2'd2:    return -longint'(quarter_sine(64'd65536 - t));
                default: return longint'(quarter_sine(t));
            endcase
        endfunction

        // a * sqrt3, q15 scale, rounded half away from zero
        function longint scale_root3(longint a);
            longint unsigned mag;
            longint          r;
            mag = (a < 0) ? longint'(-a) : a;
            r   = longint'((mag * ROOT3_Q15 + 64'd16384) >> 15);
            return (a < 0) ? -r : r;
        endfunction

        function logic [15:0] predict_duty(logic [15:0] ang, logic [15:0] mi);
            longint      m;
            longint      c0;
            longint      cm;
            longint      cp;
            longint      v;
            longint      rounded;
            logic [15:0] lag;
            logic [15:0] lead;
            m    = mi;
            lag  = ang - LAG_STEP;
            lead = ang + LAG_STEP;
            c0   = m * cos_lookup(ang);
            cm   = m * cos_lookup(lag);
            cp   = m * cos_lookup(lead);
            case (mode)
                MODE_DPWM1:
                begin
                    if (ang >= ANG_300)      v = cp + LVL_HALF;
                    else if (ang >= ANG_240) v = scale_root3(c0) + LVL_HALF;
                    else if (ang >= ANG_180) v = cm + LVL_HALF;
                    else if (ang >= ANG_120) v = cp + LVL_HALF;
                    else if (ang >= ANG_60)  v = scale_root3(c0) + LVL_HALF;
                    else                     v = cm + LVL_HALF;
                end
                MODE_DPWM2:
                begin
                    if (ang >= ANG_330)      v = LVL_ONE;
                    else if (ang >= ANG_270) v = 2 * cp;
                    else if (ang >= ANG_210) v = 2 * cm + LVL_ONE;
                    else if (ang >= ANG_150) v = 0;
                    else if (ang >= ANG_90)  v = 2 * cp + LVL_ONE;
                    else if (ang >= ANG_30)  v = 2 * cm;
                    else                     v = LVL_ONE;
                end
                MODE_DPWM3:
                begin
                    if (ang >= ANG_300)      v = 2 * cp;
                    else if (ang >= ANG_240) v = 2 * cm + LVL_ONE;
                    else if (ang >= ANG_180) v = 0;
                    else if (ang >= ANG_120) v = 2 * cp + LVL_ONE;
                    else if (ang >= ANG_60)  v = 2 * cm;
                    else                     v = LVL_ONE;
                end
                MODE_DPWM4:
                begin
                    if (ang >= ANG_240)      v = 2 * cp;
                    else if (ang >= ANG_120) v = 0;
                    else                     v = 2 * cm;
                end
                default:
                begin
                    v = c0 + LVL_HALF;
                end
            endcase
            if (v <= 0)
            begin
                return 16'd0;
            end
            if (v >= LVL_ONE)
            begin
                return FULL_ON;
            end
            rounded = (v + 64'sd32768) >>> 16;
            return rounded[15:0];
        endfunction

        function void note_request(logic [15:0] ang, logic [15:0] mi);
            duty_expect_t e;
            e.mode  = mode;
            e.angle = ang;
            e.mi    = mi;
            e.duty  = predict_duty(ang, mi);
            pending_duty.push_back(e);
            n_requests++;
        endfunction

        function void check_duty(logic [15:0] d);
            duty_expect_t e;
            n_results++;
            if (pending_duty.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t duty with no request pending: expected none, actual %0d",
                             $time, d);
                end
                return;
            end
            e = pending_duty.pop_front();
            if (e.duty == 16'd0)
            begin
                n_floor++;
            end
            if (e.duty == FULL_ON)
            begin
                n_full++;
            end
            if (d !== e.duty)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t duty mismatch (mode %0d angle %0d index %0d): expected %0d, actual %0d",
                             $time, e.mode, e.angle, e.mi, e.duty, d);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [MODE_W-1:0]   cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [ANGLE_W-1:0]  phase_angle;
    logic [MOD_W-1:0]    mod_index;
    logic                out_valid;
    logic                out_stall;
    logic [DUTY_W-1:0]   duty;

    duty_scoreboard      sb;
    bit                  feeding_steady;   // sender is mid-phase, safe to back up the pipe
    int                  long_holds;
    int                  settings_used;

    discontinuous_pwm_duty dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .phase_angle (phase_angle),
        .mod_index   (mod_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty        (duty)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge, result first so a
    // request taken on the same edge never pairs with that edge's duty
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_duty(duty);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(phase_angle, mod_index);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // uniform, close to a sector edge, or on a rom step boundary
    function automatic logic [15:0] pick_angle();
        int          r;
        logic [15:0] ang;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            ang = 16'($urandom_range(0, 65535));
        end
        else if (r < 8)
        begin
            ang = SECTOR_EDGES[$urandom_range(0, 11)] + 16'($urandom_range(0, 6)) - 16'd3;
        end
        else
        begin
            ang = 16'($urandom_range(0, 65535));
            ang = $urandom_range(0, 1) ? (ang | ROM_LOW_MASK) : (ang & ~ROM_LOW_MASK);
        end
        return ang;
    endfunction

    // full range, the useful 0..1.0 range, or one of the corner values
    function automatic logic [15:0] pick_mod();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return 16'($urandom_range(0, 65535));
        end
        if (r < 8)
        begin
            return 16'($urandom_range(0, 32768));
        end
        return MOD_EXTREMES[$urandom_range(0, 5)];
    endfunction

    // offer one request after an optional gap and hold it until taken
    task automatic send_request(input logic [15:0] ang, input logic [15:0] mi, input bit calm);
        int gap;
        gap = pick_gap(calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap)
            begin
                phase_angle = 16'($urandom);
                mod_index   = 16'($urandom);
                @(negedge clk);
            end
        end
        in_valid    = 1'b1;
        phase_angle = ang;
        mod_index   = mi;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // stop offering and let every pending duty come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // pattern register is only touched with the pipe empty
    task automatic program_pattern(input logic [MODE_W-1:0] m);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.mode     = m;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // output side: random stalls in stretches, calm stretches with none, and
    // a long hold-off while the sender is busy so the input side backs up
    // ------------------------------------------------------------------------
    initial
    begin
        int burst_left;
        int stall_left;
        int hold_at;
        int r;
        bit calm;
        burst_left = 0;
        stall_left = 0;
        hold_at    = 300;
        calm       = 1'b0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (feeding_steady && sb.n_results >= hold_at)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall = 1'b0;
                long_holds++;
                hold_at += 500;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    calm       = ($urandom_range(0, 3) == 0);
                    burst_left = $urandom_range(20, 120);
                end
                burst_left--;
                if (stall_left != 0)
                begin
                    out_stall = 1'b1;
                    stall_left--;
                end
                else if (calm)
                begin
                    out_stall = 1'b0;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                    begin
                        out_stall = 1'b0;
                    end
                    else
                    begin
                        // this cycle stalls, maybe more after it
                        out_stall  = 1'b1;
                        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(64'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit sender_calm;
        sb             = new();
        feeding_steady = 1'b0;
        long_holds     = 0;
        settings_used  = 1;   // reset value counts as the first setting
        sender_calm    = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = MODE_SINE;
        in_valid       = 1'b0;
        phase_angle    = 16'd0;
        mod_index      = 16'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners, starting on the reset pattern
        for (int k = 0; k < NUM_PROBES; k++)
        begin
            if (PROBES[k].mode != sb.mode)
            begin
                program_pattern(PROBES[k].mode);
            end
            send_request(PROBES[k].angle, PROBES[k].mi, 1'b0);
        end

        // random phases, one pattern setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_pattern(PHASE_MODES[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    sender_calm = ($urandom_range(0, 3) == 0);
                end
                feeding_steady = (i < PHASE_ITEMS / 2);
                send_request(pick_angle(), pick_mod(), sender_calm);
            end
            feeding_steady = 1'b0;
        end

        // drain, then stay idle to catch any stray duty
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run covered %0d requests and %0d duties over %0d pattern settings",
                 sb.n_requests, sb.n_results, settings_used);
        $display("%0d duties clamped to zero, %0d to full on, %0d long output hold-offs",
                 sb.n_floor, sb.n_full, long_holds);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== discontinuous_pwm_duty.f =====
src/dpwm_pkg.sv
src/discontinuous_pwm_duty.sv
tb/testbench.sv
